[design/dgac_pkg.sv]
// ----------------------------------------------------------------------------
// dgac_pkg
// Shared constants and types for the directed graph acyclicity check.
// ----------------------------------------------------------------------------
package dgac_pkg;

   // default node count of the relation
   localparam int NODES_DEF = 16;

   // fixed widths of the request word
   localparam int ROW_IDX_W = 4;
   localparam int MASK_W    = 16;

   // control sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_TAIL = 3'b100
   } state_type;

endpackage

[design/directed_graph_acyclicity_check.sv]
// ----------------------------------------------------------------------------
// directed_graph_acyclicity_check
// Decides whether a directed relation on NODES nodes has no cycle by
// repeatedly peeling away live nodes whose live successors are all gone.
// ----------------------------------------------------------------------------
// Usage
//   Request word: req_row_index, req_successor_mask, req_run_check, taken at
//   a rising edge with start high and busy low. Each word writes the successor
//   row of one node (indexes at or above NODES are dropped, mask bits above
//   the node count are dropped). A word without req_run_check gives no
//   response.
//   With req_run_check set, the row is written and then the stored relation is
//   swept: each sweep reads all R = min(NODES,16) rows from the row RAM, one a
//   cycle, and removes every live node with no live successor. After the R
//   reads, a tail state processes the last row from the registered RAM read.
//   Sweeps repeat until one removes nothing or no node is left, so a check
//   takes S sweeps with 1 <= S <= R; the response strobe rsp_valid is
//   registered from the last sweep's tail state. busy stays high until the strobe cycle.
//   Response word: rsp_is_acyclic, valid for the single cycle rsp_valid is
//   high; the receiver cannot stall it.
//   Reset: synchronous, active high; all rows read as empty afterwards, via
//   per-row valid flags, so there is no clearing pass. Rows persist across
//   checks. Nodes numbered 16 and above can never get successors and peel in
//   the first sweep.
// ----------------------------------------------------------------------------
module directed_graph_acyclicity_check #(
   parameter int NODES = dgac_pkg::NODES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [dgac_pkg::ROW_IDX_W-1:0] req_row_index,
   input  logic [dgac_pkg::MASK_W-1:0]    req_successor_mask,
   input  logic                           req_run_check,
   output logic                           rsp_valid,
   output logic                           rsp_is_acyclic
);

   // rows that can ever hold successors
   localparam int ROWS   = (NODES < dgac_pkg::MASK_W) ? NODES : dgac_pkg::MASK_W;
   localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(ROWS - 1);

   dgac_pkg::state_type state_ff, state_in;

   logic [ROWS-1:0]   row_vld_ff, row_vld_in;
   logic [ROWS-1:0]   live_ff, live_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] rd_addr_ff;
   logic              rd_vld_ff, rd_vld_in;
   logic              changed_ff, changed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_acyc_ff, rsp_acyc_in;

   logic              accept;
   logic              wr_en;
   logic              rd_en;
   logic [ROWS-1:0]   ram_rd_data;
   logic [ROWS-1:0]   row_data;
   logic              remove;
   logic [ROWS-1:0]   remove_bit;
   logic              changed_now;

   assign busy   = (state_ff != dgac_pkg::ST_IDLE);
   assign accept = start && !busy;
   assign wr_en  = accept && (32'(req_row_index) < ROWS);
   assign rd_en  = (state_ff == dgac_pkg::ST_READ);

   // adjacency row store
   dgac_ram #(
      .WIDTH (ROWS),
      .DEPTH (ROWS),
      .ADDR_W(ADDR_W)
   ) u_rows (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(req_row_index[ADDR_W-1:0]),
      .wr_data(req_successor_mask[ROWS-1:0]),
      .rd_en  (rd_en),
      .rd_addr(cnt_ff),
      .rd_data(ram_rd_data)
   );

   // a row never written since reset reads as empty
   assign row_data    = row_vld_ff[rd_addr_ff] ? ram_rd_data : '0;
   assign remove      = rd_vld_ff && live_ff[rd_addr_ff] && ((row_data & live_ff) == '0);
   assign remove_bit  = remove ? (ROWS'(1) << rd_addr_ff) : '0;
   assign changed_now = changed_ff || remove;

   // sequencer and peeling update
   always_comb begin
      state_in     = state_ff;
      row_vld_in   = row_vld_ff;
      live_in      = live_ff & ~remove_bit;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      changed_in   = changed_now;
      rsp_valid_in = 1'b0;
      rsp_acyc_in  = rsp_acyc_ff;

      if (wr_en) begin
         row_vld_in[req_row_index[ADDR_W-1:0]] = 1'b1;
      end

      unique case (state_ff)
         dgac_pkg::ST_IDLE: begin
            if (accept && req_run_check) begin
               live_in    = '1;
               cnt_in     = '0;
               changed_in = 1'b0;
               state_in   = dgac_pkg::ST_READ;
            end
         end
         dgac_pkg::ST_READ: begin
            rd_vld_in = 1'b1;
            if (cnt_ff == LAST_ROW) begin
               state_in = dgac_pkg::ST_TAIL;
            end else begin
               cnt_in = cnt_ff + ADDR_W'(1);
            end
         end
         dgac_pkg::ST_TAIL: begin
            // last row of the sweep is processed here
            if (changed_now && (live_in != '0)) begin
               cnt_in     = '0;
               changed_in = 1'b0;
               state_in   = dgac_pkg::ST_READ;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_acyc_in  = (live_in == '0);
               state_in     = dgac_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dgac_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dgac_pkg::ST_IDLE;
         row_vld_ff   <= '0;
         live_ff      <= '1;
         rd_vld_ff    <= 1'b0;
         changed_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_vld_ff   <= row_vld_in;
         live_ff      <= live_in;
         rd_vld_ff    <= rd_vld_in;
         changed_ff   <= changed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rd_addr_ff  <= cnt_ff;
      rsp_acyc_ff <= rsp_acyc_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_acyclic = rsp_acyc_ff;

`ifndef ASSERT_OFF
   // a response word only follows the last sweep's tail cycle
   a_rsp_after_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == dgac_pkg::ST_TAIL))
      else $error("response without a finished sweep");

   // the response strobe frees the request side
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy during response strobe");

   // returning row data always belongs to an active sweep
   a_rd_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == dgac_pkg::ST_READ || state_ff == dgac_pkg::ST_TAIL))
      else $error("row data outside a sweep");

   // a check request starts a sweep on the next cycle
   a_check_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_run_check |=> (state_ff == dgac_pkg::ST_READ && cnt_ff == '0))
      else $error("check did not start a sweep");

   // live nodes only ever shrink during a check
   a_live_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != dgac_pkg::ST_IDLE) && $past(state_ff != dgac_pkg::ST_IDLE)
      |-> ((live_ff & ~$past(live_ff)) == '0))
      else $error("a peeled node came back");
`endif

endmodule

[design/dgac_ram.sv]
// ----------------------------------------------------------------------------
// dgac_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module dgac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
